FILE: design/equirect_bilinear_sampler_macros.svh
// Assertion macros for the equirectangular sampler.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef EQUIRECT_BILINEAR_SAMPLER_MACROS_SVH
`define EQUIRECT_BILINEAR_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define EBS_ASSERT_IMPL(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("ebs check failed");
`define EBS_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("ebs check failed");
`else
`define EBS_ASSERT_IMPL(label, trig, cond)
`define EBS_ASSERT_NEXT(label, trig, cond)
`endif
`endif

FILE: design/ebs_pkg.sv
// Shared types and constants of the equirectangular bilinear sampler.
// No dependencies; imported by every module of the block except ebs_ram.
`timescale 1ns / 1ps
package ebs_pkg;

   // map geometry
   localparam int MAX_WIDTH      = 512;
   localparam int MAX_HEIGHT     = 256;
   localparam int TEXEL_CHANNELS = 3;
   localparam int COL_W          = $clog2(MAX_WIDTH);
   localparam int ROW_W          = $clog2(MAX_HEIGHT);
   localparam int WSIZE_W        = $clog2(MAX_WIDTH + 1);
   localparam int HSIZE_W        = $clog2(MAX_HEIGHT + 1);
   localparam int BANK_AW        = (COL_W - 1) + (ROW_W - 1);

   // field widths
   localparam int CHAN_W     = 32;
   localparam int DIR_W      = 16;
   localparam int IN_COL_W   = 9;
   localparam int IN_ROW_W   = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam int WREG_W     = 10;
   localparam int HREG_W     = 9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;

   // square root and CORDIC
   localparam int QBITS        = 14;
   localparam int ISQ_STEPS    = 15;
   localparam int ISQ_W        = 30;
   localparam int RADICAND_ONE = 1 << (2 * QBITS);
   localparam int CORD_IN_W    = DIR_W + 1;
   localparam int CORD_W       = 34;
   localparam int ANG_W        = 20;
   localparam int CORDIC_STEPS = 17;
   localparam int CORD_LAT     = CORDIC_STEPS + 1;

   localparam logic signed [DIR_W-1:0] ONE_Q14 = DIR_W'(1 << QBITS);
   localparam logic signed [ANG_W-1:0] ANG_PI  = ANG_W'(205887);

   // atan(2^-i) in radians, Q.16
   localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      ANG_W'(51472), ANG_W'(30386), ANG_W'(16055), ANG_W'(8150), ANG_W'(4091),
      ANG_W'(2047),  ANG_W'(1024),  ANG_W'(512),   ANG_W'(256),  ANG_W'(128),
      ANG_W'(64),    ANG_W'(32),    ANG_W'(16),    ANG_W'(8),    ANG_W'(4),
      ANG_W'(2),     ANG_W'(1)
   };

   // angle to unit coordinate
   localparam int UNIT_W  = 32;
   localparam int UT_W    = ANG_W + 17;
   localparam int U_SCALE = 10427;
   localparam int V_SCALE = 20860;

   // filter
   localparam int FRAC_W = 16;
   localparam int WT_W   = FRAC_W + 1;
   localparam int CW_W   = 2 * FRAC_W + 1;
   localparam int ACC_W  = 2 * CHAN_W;

   typedef logic [TEXEL_CHANNELS-1:0][CHAN_W-1:0] texel_type;

   typedef struct packed {
      logic                     func;
      logic [IN_COL_W-1:0]      texel_col;
      logic [IN_ROW_W-1:0]      texel_row;
      logic [CHAN_W-1:0]        in_red;
      logic [CHAN_W-1:0]        in_green;
      logic [CHAN_W-1:0]        in_blue;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic signed [DIR_W-1:0]  dir_z;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_type;

   // what a transaction carries beside the angle math
   typedef struct packed {
      logic                func;
      logic [IN_COL_W-1:0] col;
      logic [IN_ROW_W-1:0] row;
      texel_type           texel;
   } side_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] x;
      logic signed [DIR_W-1:0] y;
      logic signed [DIR_W-1:0] z;
   } dir_type;

endpackage

FILE: design/ebs_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps
module ebs_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 96
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/ebs_isqrt.sv
// Pipelined floor integer square root, two radicand bits per stage.
// Depends on ebs_pkg.
`timescale 1ns / 1ps
module ebs_isqrt import ebs_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [ISQ_W-1:0] radicand,
   output logic [ISQ_W-1:0] root
);

   logic [ISQ_W-1:0] rem_src  [ISQ_STEPS];
   logic [ISQ_W-1:0] root_src [ISQ_STEPS];
   logic [ISQ_W-1:0] trial    [ISQ_STEPS];
   logic [ISQ_W-1:0] rem_in   [ISQ_STEPS];
   logic [ISQ_W-1:0] root_in  [ISQ_STEPS];
   logic [ISQ_W-1:0] rem_ff   [ISQ_STEPS];
   logic [ISQ_W-1:0] root_ff  [ISQ_STEPS];

   // stage inputs: first stage from the port, others from the previous stage
   assign rem_src[0]  = radicand;
   assign root_src[0] = '0;
   for (genvar k = 1; k < ISQ_STEPS; k++) begin : g_src
      assign rem_src[k]  = rem_ff[k-1];
      assign root_src[k] = root_ff[k-1];
   end

   // one digit per stage, test bit walks down by two places
   always_comb begin
      for (int k = 0; k < ISQ_STEPS; k++) begin
         trial[k] = root_src[k] + (ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k)));
         if (rem_src[k] >= trial[k]) begin
            rem_in[k]  = rem_src[k] - trial[k];
            root_in[k] = (root_src[k] >> 1) + (ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k)));
         end else begin
            rem_in[k]  = rem_src[k];
            root_in[k] = root_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[ISQ_STEPS-1];

endmodule

FILE: design/ebs_cordic.sv
// Pipelined vectoring CORDIC: atan2(num, den) in radians Q.16.
// One setup stage plus one stage per iteration; depends on ebs_pkg.
`timescale 1ns / 1ps
module ebs_cordic import ebs_pkg::*; (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [CORD_IN_W-1:0] num,
   input  logic signed [CORD_IN_W-1:0] den,
   output logic signed [ANG_W-1:0]     angle
);

   logic signed [CORD_W-1:0] p_in   [CORD_LAT];
   logic signed [CORD_W-1:0] q_in   [CORD_LAT];
   logic signed [ANG_W-1:0]  ang_in [CORD_LAT];
   logic                     zero_in[CORD_LAT];
   logic signed [CORD_W-1:0] p_ff   [CORD_LAT];
   logic signed [CORD_W-1:0] q_ff   [CORD_LAT];
   logic signed [ANG_W-1:0]  ang_ff [CORD_LAT];
   logic                     zero_ff[CORD_LAT];
   logic signed [CORD_W-1:0] num_ext;
   logic signed [CORD_W-1:0] den_ext;

   assign num_ext = CORD_W'(num);
   assign den_ext = CORD_W'(den);

   always_comb begin
      // setup: fold negative den into the right half plane
      zero_in[0] = (num == '0) && (den == '0);
      if (den < 0) begin
         p_in[0]   = (-den_ext) <<< QBITS;
         q_in[0]   = (-num_ext) <<< QBITS;
         ang_in[0] = (num >= 0) ? ANG_PI : -ANG_PI;
      end else begin
         p_in[0]   = den_ext <<< QBITS;
         q_in[0]   = num_ext <<< QBITS;
         ang_in[0] = '0;
      end
      // iterations: drive q toward zero
      for (int s = 1; s < CORD_LAT; s++) begin
         zero_in[s] = zero_ff[s-1];
         if (!q_ff[s-1][CORD_W-1]) begin
            p_in[s]   = p_ff[s-1] + (q_ff[s-1] >>> (s - 1));
            q_in[s]   = q_ff[s-1] - (p_ff[s-1] >>> (s - 1));
            ang_in[s] = ang_ff[s-1] + ATAN_TAB[s-1];
         end else begin
            p_in[s]   = p_ff[s-1] - (q_ff[s-1] >>> (s - 1));
            q_in[s]   = q_ff[s-1] + (p_ff[s-1] >>> (s - 1));
            ang_in[s] = ang_ff[s-1] - ATAN_TAB[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         ang_ff  <= ang_in;
         zero_ff <= zero_in;
      end
   end

   // zero vector gives angle zero
   assign angle = zero_ff[CORD_LAT-1] ? '0 : ang_ff[CORD_LAT-1];

endmodule

FILE: design/equirect_bilinear_sampler.sv
// Writes give no result.
// Throughput: one transaction per cycle; the whole pipeline holds only while
// the output register is full and not taken.
// Corner texels come from four row/column parity banks, one read each per cycle while the pipeline advances.
// Reset clears valid bits and sets map size to 512 x 256; texels stay undefined.
`timescale 1ns / 1ps
`include "equirect_bilinear_sampler_macros.svh"
module equirect_bilinear_sampler import ebs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SIDE_LEN = ISQ_STEPS + CORD_LAT;
   localparam int POSX_W   = UNIT_W + WSIZE_W;
   localparam int POSY_W   = UNIT_W + HSIZE_W;

   logic advance;

   // configuration
   logic [WREG_W-1:0]  map_width_ff;
   logic [HREG_W-1:0]  map_height_ff;
   logic [WSIZE_W-1:0] w_eff_ff;
   logic [HSIZE_W-1:0] h_eff_ff;

   // input stage
   logic                    s0_valid_ff;
   side_type                s0_side_ff;
   dir_type                 s0_dir_ff;
   logic [ISQ_W-1:0]        s0_rad_ff;
   logic signed [DIR_W-1:0] y_clamp;
   logic signed [2*DIR_W-1:0] y_sq;

   // delay lines beside the angle math
   logic     side_vld_ff [SIDE_LEN];
   side_type side_ff     [SIDE_LEN];
   dir_type  dir_ff      [ISQ_STEPS];

   logic [ISQ_W-1:0]           isq_root;
   logic signed [ANG_W-1:0]    ang_u;
   logic signed [ANG_W-1:0]    ang_v;

   // stage A: unit coordinates
   logic                    a_valid_ff;
   side_type                a_side_ff;
   logic [UNIT_W-1:0]       a_u_ff;
   logic [UNIT_W-1:0]       a_v_ff;
   logic signed [UT_W-1:0]  t_u;
   logic signed [UT_W-1:0]  t_v;

   // stage B: map positions
   logic              b_valid_ff;
   side_type          b_side_ff;
   logic [POSX_W-1:0] b_posx_ff;
   logic [POSY_W-1:0] b_posy_ff;

   // stage C: corner indexes
   logic               c_valid_ff;
   side_type           c_side_ff;
   logic [COL_W-1:0]   c_cx_ff [2];
   logic [ROW_W-1:0]   c_cy_ff [2];
   logic [FRAC_W-1:0]  c_fx_ff;
   logic [FRAC_W-1:0]  c_fy_ff;
   logic [WSIZE_W-1:0] x_lo;
   logic [WSIZE_W:0]   x_hi;
   logic [HSIZE_W-1:0] y_lo;
   logic [HSIZE_W:0]   y_hi;
   logic               wr_ok;

   // stage D: bank reads and weights
   logic              d_valid_ff;
   logic              d_func_ff;
   logic              d_cxp_ff [2];
   logic              d_cyp_ff [2];
   logic [CW_W-1:0]   d_wt_ff  [4];
   logic [CW_W-1:0]   wt_in    [4];
   logic [WT_W-1:0]   wx [2];
   logic [WT_W-1:0]   wy [2];
   texel_type         bank_rdata [4];

   // stages E, F: products and partial sums
   logic              e_valid_ff;
   logic              e_func_ff;
   logic [ACC_W-1:0]  e_prod_ff [4][TEXEL_CHANNELS];
   logic [ACC_W-1:0]  prod_in   [4][TEXEL_CHANNELS];
   logic              f_valid_ff;
   logic              f_func_ff;
   logic [ACC_W-1:0]  f_sum_ff [TEXEL_CHANNELS][2];
   logic [ACC_W-1:0]  acc      [TEXEL_CHANNELS];

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // check helpers
   logic [CW_W+1:0] wt_sum;
   logic            corner_ok;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // configuration registers and effective sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= WREG_W'(MAX_WIDTH);
         map_height_ff <= HREG_W'(MAX_HEIGHT);
         w_eff_ff      <= WSIZE_W'(MAX_WIDTH);
         h_eff_ff      <= HSIZE_W'(MAX_HEIGHT);
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[WREG_W-1:0];
               CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[HREG_W-1:0];
            endcase
         end
         if (map_width_ff == '0)
            w_eff_ff <= WSIZE_W'(1);
         else if (32'(map_width_ff) > MAX_WIDTH)
            w_eff_ff <= WSIZE_W'(MAX_WIDTH);
         else
            w_eff_ff <= WSIZE_W'(map_width_ff);
         if (map_height_ff == '0)
            h_eff_ff <= HSIZE_W'(1);
         else if (32'(map_height_ff) > MAX_HEIGHT)
            h_eff_ff <= HSIZE_W'(MAX_HEIGHT);
         else
            h_eff_ff <= HSIZE_W'(map_height_ff);
      end
   end

   // input stage: clamp y, form 1 - y^2 for the square root
   always_comb begin
      if (req_data.dir_y > ONE_Q14)
         y_clamp = ONE_Q14;
      else if (req_data.dir_y < -ONE_Q14)
         y_clamp = -ONE_Q14;
      else
         y_clamp = req_data.dir_y;
      y_sq = y_clamp * y_clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_side_ff <= '{func: req_data.func, col: req_data.texel_col,
                         row: req_data.texel_row,
                         texel: {req_data.in_blue, req_data.in_green, req_data.in_red}};
         s0_dir_ff  <= '{x: req_data.dir_x, y: y_clamp, z: req_data.dir_z};
         s0_rad_ff  <= ISQ_W'(RADICAND_ONE - 32'(y_sq));
      end
   end

   // delay lines that keep transaction data aligned with the math
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_LEN; k++) side_vld_ff[k] <= 1'b0;
      end else if (advance) begin
         side_vld_ff[0] <= s0_valid_ff;
         for (int k = 1; k < SIDE_LEN; k++) side_vld_ff[k] <= side_vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= s0_side_ff;
         for (int k = 1; k < SIDE_LEN; k++) side_ff[k] <= side_ff[k-1];
         dir_ff[0] <= s0_dir_ff;
         for (int k = 1; k < ISQ_STEPS; k++) dir_ff[k] <= dir_ff[k-1];
      end
   end

   ebs_isqrt u_isqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (s0_rad_ff),
      .root     (isq_root)
   );

   // horizontal angle from (z, x)
   ebs_cordic u_cordic_u (
      .clock   (clock),
      .advance (advance),
      .num     (CORD_IN_W'(dir_ff[ISQ_STEPS-1].z)),
      .den     (CORD_IN_W'(dir_ff[ISQ_STEPS-1].x)),
      .angle   (ang_u)
   );

   // vertical angle: asin(y) = atan2(y, sqrt(1 - y^2))
   ebs_cordic u_cordic_v (
      .clock   (clock),
      .advance (advance),
      .num     (CORD_IN_W'(dir_ff[ISQ_STEPS-1].y)),
      .den     ($signed({1'b0, isq_root[CORD_IN_W-2:0]})),
      .angle   (ang_v)
   );

   // stage A: scale angle to [0,1) Q0.32 with saturation
   function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [UT_W-1:0] t);
      if (t[UT_W-1])
         return '0;
      else if (|t[UT_W-2:UNIT_W])
         return '1;
      else
         return t[UNIT_W-1:0];
   endfunction

   always_comb begin
      t_u = UT_W'(ang_u) * UT_W'(U_SCALE) + (UT_W'(1) <<< (UNIT_W - 1));
      t_v = UT_W'(ang_v) * UT_W'(V_SCALE) + (UT_W'(1) <<< (UNIT_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= side_vld_ff[SIDE_LEN-1];
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= side_ff[SIDE_LEN-1];
         a_u_ff    <= clamp_unit(t_u);
         a_v_ff    <= clamp_unit(t_v);
         // stage B: position on the map
         b_side_ff <= a_side_ff;
         b_posx_ff <= POSX_W'(a_u_ff) * POSX_W'(w_eff_ff);
         b_posy_ff <= POSY_W'(a_v_ff) * POSY_W'(h_eff_ff);
      end
   end

   // stage C: floor/ceil with fallback and clamp at the edge
   always_comb begin
      x_lo = b_posx_ff[POSX_W-1:UNIT_W];
      x_hi = {1'b0, x_lo} + (WSIZE_W + 1)'(|b_posx_ff[UNIT_W-1:0]);
      if (x_hi >= {1'b0, w_eff_ff}) x_hi = {1'b0, x_lo};
      if (x_lo > w_eff_ff - 1'b1) x_lo = w_eff_ff - 1'b1;
      if (x_hi > {1'b0, w_eff_ff - 1'b1}) x_hi = {1'b0, w_eff_ff - 1'b1};
   end

   always_comb begin
      y_lo = b_posy_ff[POSY_W-1:UNIT_W];
      y_hi = {1'b0, y_lo} + (HSIZE_W + 1)'(|b_posy_ff[UNIT_W-1:0]);
      if (y_hi >= {1'b0, h_eff_ff}) y_hi = {1'b0, y_lo};
      if (y_lo > h_eff_ff - 1'b1) y_lo = h_eff_ff - 1'b1;
      if (y_hi > {1'b0, h_eff_ff - 1'b1}) y_hi = {1'b0, h_eff_ff - 1'b1};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_side_ff  <= b_side_ff;
         c_cx_ff[0] <= x_lo[COL_W-1:0];
         c_cx_ff[1] <= x_hi[COL_W-1:0];
         c_cy_ff[0] <= y_lo[ROW_W-1:0];
         c_cy_ff[1] <= y_hi[ROW_W-1:0];
         c_fx_ff    <= b_posx_ff[UNIT_W-1:UNIT_W-FRAC_W];
         c_fy_ff    <= b_posy_ff[UNIT_W-1:UNIT_W-FRAC_W];
      end
   end

   // stage D: texel banks split by row and column parity; writes land here too
   assign wr_ok = (32'(c_side_ff.col) < MAX_WIDTH) && (32'(c_side_ff.row) < MAX_HEIGHT);

   for (genvar rp = 0; rp < 2; rp++) begin : g_row
      for (genvar cp = 0; cp < 2; cp++) begin : g_col
         logic [COL_W-1:0] rcol;
         logic [ROW_W-1:0] rrow;
         logic             bank_we;

         assign rcol = (c_cx_ff[0][0] == 1'(cp)) ? c_cx_ff[0] : c_cx_ff[1];
         assign rrow = (c_cy_ff[0][0] == 1'(rp)) ? c_cy_ff[0] : c_cy_ff[1];
         assign bank_we = advance && c_valid_ff && !c_side_ff.func && wr_ok
                          && (c_side_ff.row[0] == 1'(rp)) && (c_side_ff.col[0] == 1'(cp));

         ebs_ram #(
            .ADDR_W (BANK_AW),
            .DATA_W ($bits(texel_type))
         ) u_bank (
            .clock (clock),
            .we    (bank_we),
            .waddr ({c_side_ff.row[ROW_W-1:1], c_side_ff.col[COL_W-1:1]}),
            .wdata (c_side_ff.texel),
            .re    (advance),
            .raddr ({rrow[ROW_W-1:1], rcol[COL_W-1:1]}),
            .rdata (bank_rdata[rp*2+cp])
         );
      end
   end

   // bilinear weights, corner index = row side * 2 + column side
   always_comb begin
      wx[0] = WT_W'(1 << FRAC_W) - WT_W'(c_fx_ff);
      wx[1] = WT_W'(c_fx_ff);
      wy[0] = WT_W'(1 << FRAC_W) - WT_W'(c_fy_ff);
      wy[1] = WT_W'(c_fy_ff);
      for (int b = 0; b < 2; b++) begin
         for (int a = 0; a < 2; a++) begin
            wt_in[b*2+a] = CW_W'(CW_W'(wx[a]) * CW_W'(wy[b]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_func_ff   <= c_side_ff.func;
         d_cxp_ff[0] <= c_cx_ff[0][0];
         d_cxp_ff[1] <= c_cx_ff[1][0];
         d_cyp_ff[0] <= c_cy_ff[0][0];
         d_cyp_ff[1] <= c_cy_ff[1][0];
         d_wt_ff     <= wt_in;
      end
   end

   // stage E: texel times weight; each product stays below 2^64
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int a = 0; a < 2; a++) begin
            for (int ch = 0; ch < TEXEL_CHANNELS; ch++) begin
               prod_in[b*2+a][ch] = ACC_W'(
                  (ACC_W + 1)'(bank_rdata[{d_cyp_ff[b], d_cxp_ff[a]}][ch])
                  * (ACC_W + 1)'(d_wt_ff[b*2+a]));
            end
         end
      end
   end

   // stage F sums pairs; final stage rounds. Weights sum to 2^32, so no overflow.
   always_comb begin
      for (int ch = 0; ch < TEXEL_CHANNELS; ch++) begin
         acc[ch] = f_sum_ff[ch][0] + f_sum_ff[ch][1] + (ACC_W'(1) << (CHAN_W - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_func_ff <= d_func_ff;
         e_prod_ff <= prod_in;
         f_func_ff <= e_func_ff;
         for (int ch = 0; ch < TEXEL_CHANNELS; ch++) begin
            f_sum_ff[ch][0] <= e_prod_ff[0][ch] + e_prod_ff[1][ch];
            f_sum_ff[ch][1] <= e_prod_ff[2][ch] + e_prod_ff[3][ch];
         end
         rsp_data_ff <= '{out_red:   acc[0][ACC_W-1:CHAN_W],
                          out_green: acc[1][ACC_W-1:CHAN_W],
                          out_blue:  acc[2][ACC_W-1:CHAN_W]};
      end
   end

   // output register: only samples produce a transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= f_valid_ff && f_func_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   assign wt_sum    = {2'b00, d_wt_ff[0]} + {2'b00, d_wt_ff[1]}
                    + {2'b00, d_wt_ff[2]} + {2'b00, d_wt_ff[3]};
   assign corner_ok = (c_cx_ff[1] == c_cx_ff[0]) || (c_cx_ff[1] == c_cx_ff[0] + 1'b1);

   `EBS_ASSERT_IMPL(a_hold_when_full, rsp_valid_ff && !rsp_ready, !req_ready)
   `EBS_ASSERT_NEXT(a_write_no_rsp, advance && f_valid_ff && !f_func_ff, !rsp_valid_ff)
   `EBS_ASSERT_IMPL(a_corner_step, c_valid_ff && c_side_ff.func, corner_ok)
   `EBS_ASSERT_IMPL(a_weight_sum, d_valid_ff && d_func_ff, wt_sum == (CW_W + 2)'(64'h1_0000_0000))

endmodule
